// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

	// storage geometry
	localparam int DEPTH = 16;
	localparam int WIDTH = 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	// field widths of one item
	localparam int KIND_W = 3;
	localparam int ELEM_W = 32;
	localparam int POS_W  = 4;
	localparam int OUT_W  = 2;
	localparam int FILL_W = 5;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

	// outcome codes
	localparam logic [OUT_W-1:0] OUT_OK   = 2'd0;
	localparam logic [OUT_W-1:0] OUT_WARN = 2'd1;
	localparam logic [OUT_W-1:0] OUT_ERR  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ELEM_W-1:0] element;
		logic [POS_W-1:0]  position;
	} cdq_cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0]  outcome;
		logic [ELEM_W-1:0] read_value;
		logic [FILL_W-1:0] fill_count;
	} cdq_res_t;

endpackage

// ===== sv/circular_deque_with_indexed_read_top.sv =====
// a result strobes on done in the cycle after its item is accepted
// throughput: one item per cycle, busy stays low since every operation
// touches the slot memory at most once at the accept edge
// the receiver cannot stall, so each result is shown for exactly one cycle
// reset clears head position and fill count; slot contents stay undefined
module circular_deque_with_indexed_read_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cdq_pkg::cdq_cmd_t cmd,
	output logic             done,
	output cdq_pkg::cdq_res_t result
);
	import cdq_pkg::*;

	localparam int IW = (POS_W > CW) ? POS_W : CW;

	logic [AW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic              accept;
	logic              full, empty;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [WIDTH-1:0]  wdata, rdata;
	logic [OUT_W-1:0]  outcome_d;
	logic              rd_ok_d;
	logic              done_q;
	logic              rd_ok_s1;
	logic [OUT_W-1:0]  outcome_s1;
	logic [CW-1:0]     fill_s1;

	// physical slot of a logical offset from head
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, h} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign wdata  = WIDTH'(cmd.element);
	assign raddr  = slot_of(head_q, AW'(cmd.position));

	// operation decode and next state
	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		we        = 1'b0;
		waddr     = slot_of(head_q, count_q[AW-1:0]);
		outcome_d = OUT_OK;
		rd_ok_d   = 1'b0;
		case (cmd.kind)
			KIND_PUSH_FRONT: begin
				if (full) begin
					outcome_d = OUT_ERR;
				end else begin
					head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
					waddr   = head_d;
					we      = accept;
					count_d = count_q + CW'(1);
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					outcome_d = OUT_ERR;
				end else begin
					we      = accept;
					count_d = count_q + CW'(1);
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					outcome_d = OUT_WARN;
				end else begin
					head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
					count_d = count_q - CW'(1);
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					outcome_d = OUT_WARN;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			KIND_READ: begin
				if (IW'(cmd.position) >= IW'(count_q)) begin
					outcome_d = OUT_ERR;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			default: begin
				outcome_d = OUT_ERR;
			end
		endcase
	end

	// slot storage
	cdq_ram #(
		.W(WIDTH),
		.D(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// head and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
		end
	end

	// result stage, lines up with the memory read data
	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_s1 <= outcome_d;
			rd_ok_s1   <= rd_ok_d;
			fill_s1    <= count_d;
		end
	end

	assign done              = done_q;
	assign result.outcome    = outcome_s1;
	assign result.read_value = rd_ok_s1 ? ELEM_W'(rdata) : '0;
	assign result.fill_count = FILL_W'(fill_s1);

	// every accepted item strobes one result next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without an item");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.fill_count <= FILL_W'(DEPTH)))
		else $error("fill count beyond capacity");

	a_warn_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome == OUT_WARN) |-> (result.fill_count == '0))
		else $error("pop warning while not empty");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome != OUT_OK) |-> (result.read_value == '0))
		else $error("read value on failed item");

endmodule

// ===== sv/cdq_ram.sv =====
module cdq_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                        wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                        rdata
);

	logic [W-1:0] mem [D];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
